>>> hdl/swh_pkg.sv
// ----------------------------------------------------------------------------
// swh_pkg
// Shared types and constants for the stereo widener with Haas delay.
// ----------------------------------------------------------------------------
package swh_pkg;

   localparam int DELAY_DEPTH_DEF = 4096;
   localparam int SAMPLE_BITS_DEF = 24;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   // Register reset values.
   localparam logic [15:0] WIDTH_RESET = 16'd29491;
   localparam logic [15:0] MONO_RESET  = 16'd45875;
   localparam logic [15:0] MIX_RESET   = 16'd65535;
   localparam logic [14:0] GAIN_RESET  = 15'd4096;
   localparam logic [11:0] DELAY_RESET = 12'd576;

   // ceil(2^18 / 5): floor(q * RECIP5 / 2^18) equals floor(q / 5) for q below 2^18.
   localparam logic [15:0] RECIP5 = 16'd52429;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WIDTH = 3'd0,
      CSR_MONO  = 3'd1,
      CSR_MIX   = 3'd2,
      CSR_GAIN  = 3'd3,
      CSR_DELAY = 3'd4
   } csr_idx_type;

   // Controller to datapath: one strobe for each processing step.
   typedef struct packed {
      logic ld_in;
      logic do_prod;
      logic do_shr;
      logic do_ww;
      logic do_side;
      logic do_wetl;
      logic do_wetr;
      logic do_wr;
      logic do_rd;
      logic do_mixl;
      logic do_mixr;
      logic do_gainl;
      logic do_gainr;
      logic ld_out;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

>>> hdl/swh_ctrl.sv
// ----------------------------------------------------------------------------
// swh_ctrl
// Sequencer that steps the datapath through one stereo pair at a time.
// ----------------------------------------------------------------------------
module swh_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  swh_pkg::status_type status,
   output swh_pkg::cmd_type    cmd
);
   import swh_pkg::*;

   typedef enum logic [13:0] {
      S_IDLE  = 14'b00000000000001,
      S_PROD  = 14'b00000000000010,
      S_SHR   = 14'b00000000000100,
      S_WW    = 14'b00000000001000,
      S_SIDE  = 14'b00000000010000,
      S_WETL  = 14'b00000000100000,
      S_WETR  = 14'b00000001000000,
      S_WRITE = 14'b00000010000000,
      S_READ  = 14'b00000100000000,
      S_MIXL  = 14'b00001000000000,
      S_MIXR  = 14'b00010000000000,
      S_GAINL = 14'b00100000000000,
      S_GAINR = 14'b01000000000000,
      S_DONE  = 14'b10000000000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_PROD;
         S_PROD:  state_in = S_SHR;
         S_SHR:   state_in = S_WW;
         S_WW:    state_in = S_SIDE;
         S_SIDE:  state_in = S_WETL;
         S_WETL:  state_in = S_WETR;
         S_WETR:  state_in = S_WRITE;
         S_WRITE: state_in = S_READ;
         S_READ:  state_in = S_MIXL;
         S_MIXL:  state_in = S_MIXR;
         S_MIXR:  state_in = S_GAINL;
         S_GAINL: state_in = S_GAINR;
         S_GAINR: state_in = S_DONE;
         S_DONE:  if (status.out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd          = '0;
      cmd.ld_in    = (state_ff == S_IDLE) && req_valid;
      cmd.do_prod  = (state_ff == S_PROD);
      cmd.do_shr   = (state_ff == S_SHR);
      cmd.do_ww    = (state_ff == S_WW);
      cmd.do_side  = (state_ff == S_SIDE);
      cmd.do_wetl  = (state_ff == S_WETL);
      cmd.do_wetr  = (state_ff == S_WETR);
      cmd.do_wr    = (state_ff == S_WRITE);
      cmd.do_rd    = (state_ff == S_READ);
      cmd.do_mixl  = (state_ff == S_MIXL);
      cmd.do_mixr  = (state_ff == S_MIXR);
      cmd.do_gainl = (state_ff == S_GAINL);
      cmd.do_gainr = (state_ff == S_GAINR);
      cmd.ld_out   = (state_ff == S_DONE) && status.out_free;
   end

endmodule

>>> hdl/swh_dp.sv
// ----------------------------------------------------------------------------
// swh_dp
// Datapath: control registers, width tracking, mid/side widening, delay
// line, wet/dry blend, output gain and the result register.
// ----------------------------------------------------------------------------
module swh_dp #(
   parameter int DELAY_DEPTH = swh_pkg::DELAY_DEPTH_DEF,
   parameter int SAMPLE_BITS = swh_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [swh_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [swh_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  logic signed [SAMPLE_BITS-1:0]       req_left_in,
   input  logic signed [SAMPLE_BITS-1:0]       req_right_in,
   input  logic                                req_block_start,
   input  swh_pkg::cmd_type                    cmd,
   output swh_pkg::status_type                 status,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic signed [SAMPLE_BITS-1:0]       rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0]       rsp_right_out
);
   import swh_pkg::*;

   localparam int SB   = SAMPLE_BITS;
   localparam int AW   = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
   localparam int DW   = (AW > 12) ? AW : 12;
   localparam int PW   = 2 * SB;
   localparam int SW   = SB + 19;   // side product and mix products
   localparam int WAW  = SB + 20;   // wet accumulator
   localparam int GW   = SB + 17;   // gain product

   localparam logic signed [PW-1:0] NEG_LIMIT =
      -$signed(PW'((64'd1 << (2 * SB - 2)) / 64'd120));
   localparam logic signed [WAW-1:0] WET_MAX = WAW'((64'sd1 <<< (SB - 1)) - 64'sd1);
   localparam logic signed [WAW-1:0] WET_MIN = -WET_MAX - WAW'(1);
   localparam logic signed [GW-1:0]  OUT_MAX = GW'((64'sd1 <<< (SB - 1)) - 64'sd1);
   localparam logic signed [GW-1:0]  OUT_MIN = -OUT_MAX - GW'(1);

   // Control registers.
   logic [15:0] width_ff;
   logic [15:0] mono_ff;
   logic [15:0] mix_ff;
   logic [14:0] gain_ff;
   logic [11:0] delay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
         mono_ff  <= MONO_RESET;
         mix_ff   <= MIX_RESET;
         gain_ff  <= GAIN_RESET;
         delay_ff <= DELAY_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WIDTH: width_ff <= csr_wdata;
            CSR_MONO:  mono_ff  <= csr_wdata;
            CSR_MIX:   mix_ff   <= csr_wdata;
            CSR_GAIN:  gain_ff  <= csr_wdata[14:0];
            CSR_DELAY: delay_ff <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // Payload registers.
   logic signed [SB-1:0]  left_ff, right_ff;
   logic signed [PW-1:0]  prod_ff;
   logic [17:0]           num_ff;
   logic [33:0]           recip_ff;
   logic                  anti_ff;
   logic signed [SB+16:0] sum_ff;
   logic signed [SW-1:0]  side_ff;
   logic signed [SB-1:0]  wetl_ff, wetr_ff;
   logic signed [SB-1:0]  rd_data_ff;
   logic                  rd_valid_ff;
   logic [AW-1:0]         rdaddr_ff;
   logic signed [SW-1:0]  mprod_l_ff, mprod_r_ff;
   logic signed [SB:0]    b_l_ff, b_r_ff;
   logic signed [GW-1:0]  gl_ff, gr_ff;
   logic signed [SB-1:0]  out_l_ff, out_r_ff;

   // Control state.
   logic [15:0]  ww_ff;
   logic [15:0]  ww_in;
   logic [AW-1:0] wi_ff;
   logic [AW:0]   fc_ff;
   logic          rsp_valid_ff;

   logic [SB-1:0] dline_mem [DELAY_DEPTH];

   // Width shrink: f = 65536 - round((mono * 13) / 20), via floor((n / 4) / 5).
   logic [19:0] num_in;
   logic [16:0] shrink;
   logic [32:0] ww_prod;

   assign num_in  = 20'(mono_ff) * 20'd13 + 20'd10;
   assign shrink  = 17'h10000 - 17'(recip_ff[33:18]);
   assign ww_prod = 33'(ww_ff) * 33'(shrink) + 33'd32768;
   assign ww_in   = ww_prod[31:16];

   // Mid/side.
   logic signed [SB:0]   sum_in, diff_in;
   logic signed [17:0]   side_fac;

   assign sum_in   = $signed({left_ff[SB-1], left_ff}) + $signed({right_ff[SB-1], right_ff});
   assign diff_in  = $signed({left_ff[SB-1], left_ff}) - $signed({right_ff[SB-1], right_ff});
   assign side_fac = $signed({1'b0, 17'h10000 + 17'(ww_ff)});

   // Wet sums: round to nearest by adding half an LSB, then floor shift.
   logic signed [WAW-1:0] wetl_acc, wetr_acc, wetl_sh, wetr_sh;
   logic signed [SB-1:0]  wetl_sat, wetr_sat;

   assign wetl_acc = WAW'(sum_ff) + WAW'(side_ff) + WAW'(65536);
   assign wetr_acc = WAW'(sum_ff) - WAW'(side_ff) + WAW'(65536);
   assign wetl_sh  = wetl_acc >>> 17;
   assign wetr_sh  = wetr_acc >>> 17;

   always_comb begin
      if (wetl_sh > WET_MAX)      wetl_sat = WET_MAX[SB-1:0];
      else if (wetl_sh < WET_MIN) wetl_sat = WET_MIN[SB-1:0];
      else                        wetl_sat = wetl_sh[SB-1:0];
      if (wetr_sh > WET_MAX)      wetr_sat = WET_MAX[SB-1:0];
      else if (wetr_sh < WET_MIN) wetr_sat = WET_MIN[SB-1:0];
      else                        wetr_sat = wetr_sh[SB-1:0];
   end

   // Delay line addressing. The delay is taken modulo the line depth.
   logic [DW-1:0] dly_ext;
   logic [AW-1:0] dly_mod;
   logic [AW-1:0] rdaddr_in;

   assign dly_ext   = DW'(delay_ff);
   assign dly_mod   = dly_ext[AW-1:0];
   assign rdaddr_in = wi_ff - dly_mod;

   // Blend. A mix of all ones means exactly fully wet.
   logic [16:0]          mix_q;
   logic signed [17:0]   mix_fac;
   logic signed [SB:0]   dl_diff, dr_diff;
   logic signed [SB-1:0] wetr_sel;

   assign mix_q    = (mix_ff == 16'hFFFF) ? 17'h10000 : {1'b0, mix_ff};
   assign mix_fac  = $signed({1'b0, mix_q});
   assign wetr_sel = rd_valid_ff ? rd_data_ff : '0;
   assign dl_diff  = $signed({wetl_ff[SB-1], wetl_ff}) - $signed({left_ff[SB-1], left_ff});
   assign dr_diff  = $signed({wetr_sel[SB-1], wetr_sel})
                     - $signed({right_ff[SB-1], right_ff});

   logic signed [WAW-1:0] bl_acc, br_acc, bl_sh, br_sh;

   assign bl_acc = (WAW'(left_ff) <<< 16) + WAW'(mprod_l_ff) + WAW'(32768);
   assign br_acc = (WAW'(right_ff) <<< 16) + WAW'(mprod_r_ff) + WAW'(32768);
   assign bl_sh  = bl_acc >>> 16;
   assign br_sh  = br_acc >>> 16;

   // Output gain.
   logic signed [15:0]   gain_fac;
   logic signed [GW-1:0] ol_sh, or_sh;
   logic signed [SB-1:0] ol_sat, or_sat;

   assign gain_fac = $signed({1'b0, gain_ff});
   assign ol_sh    = (gl_ff + GW'(2048)) >>> 12;
   assign or_sh    = (gr_ff + GW'(2048)) >>> 12;

   always_comb begin
      if (ol_sh > OUT_MAX)      ol_sat = OUT_MAX[SB-1:0];
      else if (ol_sh < OUT_MIN) ol_sat = OUT_MIN[SB-1:0];
      else                      ol_sat = ol_sh[SB-1:0];
      if (or_sh > OUT_MAX)      or_sat = OUT_MAX[SB-1:0];
      else if (or_sh < OUT_MIN) or_sat = OUT_MIN[SB-1:0];
      else                      or_sat = or_sh[SB-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.ld_in) begin
         left_ff  <= req_left_in;
         right_ff <= req_right_in;
      end
      if (cmd.do_prod) begin
         prod_ff <= left_ff * right_ff;
         num_ff  <= num_in[19:2];
      end
      if (cmd.do_shr) begin
         anti_ff  <= (prod_ff < NEG_LIMIT);
         recip_ff <= 34'(num_ff) * 34'(RECIP5);
      end
      if (cmd.do_side) begin
         sum_ff  <= {sum_in, 16'b0};
         side_ff <= diff_in * side_fac;
      end
      if (cmd.do_wetl) wetl_ff <= wetl_sat;
      if (cmd.do_wetr) wetr_ff <= wetr_sat;
      if (cmd.do_wr)   rdaddr_ff <= rdaddr_in;
      if (cmd.do_rd) begin
         rd_data_ff  <= dline_mem[rdaddr_ff];
         rd_valid_ff <= ({1'b0, dly_mod} < fc_ff);
      end
      if (cmd.do_mixl) mprod_l_ff <= dl_diff * mix_fac;
      if (cmd.do_mixr) begin
         mprod_r_ff <= dr_diff * mix_fac;
         b_l_ff     <= bl_sh[SB:0];
      end
      if (cmd.do_gainl) begin
         b_r_ff <= br_sh[SB:0];
         gl_ff  <= b_l_ff * gain_fac;
      end
      if (cmd.do_gainr) gr_ff <= b_r_ff * gain_fac;
      if (cmd.ld_out) begin
         out_l_ff <= ol_sat;
         out_r_ff <= or_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_wr) begin
         dline_mem[wi_ff] <= wetr_ff;
      end
   end

   // The fill count stands in for clearing the line: an entry more than
   // fill count writes back has never been written and reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         ww_ff        <= WIDTH_RESET;
         wi_ff        <= '0;
         fc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.ld_in && req_block_start) begin
            ww_ff <= width_ff;
         end else if (cmd.do_ww && anti_ff) begin
            ww_ff <= ww_in;
         end
         if (cmd.do_wr) begin
            wi_ff <= wi_ff + 1'b1;
            if (fc_ff != (AW+1)'(DELAY_DEPTH)) begin
               fc_ff <= fc_ff + 1'b1;
            end
         end
         if (cmd.ld_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_out    = out_l_ff;
   assign rsp_right_out   = out_r_ff;

endmodule

>>> hdl/stereo_widener_haas_delay_top.sv
// ----------------------------------------------------------------------------
// stereo_widener_haas_delay_top
// Mid/side stereo widener with anti-correlation width guard and Haas delay.
// ----------------------------------------------------------------------------
// Usage:
//   One stereo pair enters as a beat on the req_ channel (valid/ready) and
//   one processed pair leaves as a beat on the rsp_ channel.
//   The block handles one pair at a time. req_ready is high only while the
//   sequencer is idle; a pair is accepted, then stepped through the datapath
//   steps (product, shift, width, side, wet, write, read, mix and gain) and
//   loaded into the output register; no new pair is taken until then.
//   The result sits in an output register, so the next pair is accepted
//   while the last result still waits. If the receiver stalls, the block
//   finishes the next pair and then holds it until the output register frees.
//   Control registers are written through csr_we/csr_index/csr_wdata; the user
//   must write them only while no pair is in flight, which the block does not
//   enforce. A width change takes effect at block_start.
//   Reset (synchronous) restores the register defaults, the working width
//   and an empty delay line at once: no clearing pass is needed.
//   DELAY_DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module stereo_widener_haas_delay_top #(
   parameter int DELAY_DEPTH = swh_pkg::DELAY_DEPTH_DEF,
   parameter int SAMPLE_BITS = swh_pkg::SAMPLE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [swh_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [swh_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [SAMPLE_BITS-1:0]      req_left_in,
   input  logic signed [SAMPLE_BITS-1:0]      req_right_in,
   input  logic                               req_block_start,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]      rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0]      rsp_right_out
);
   import swh_pkg::*;

   cmd_type    cmd;
   status_type status;

   swh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   swh_dp #(
      .DELAY_DEPTH (DELAY_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_left_in     (req_left_in),
      .req_right_in    (req_right_in),
      .req_block_start (req_block_start),
      .cmd             (cmd),
      .status          (status),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_left_out    (rsp_left_out),
      .rsp_right_out   (rsp_right_out)
   );

   // A finished pair never overwrites a result that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.ld_out |-> (!rsp_valid || rsp_ready))
      else $error("result register loaded while a result was stalled");

   // Loading the result register raises rsp_valid on the next cycle.
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.ld_out |=> rsp_valid)
      else $error("rsp_valid not raised after result load");

   // Only one pair is in flight: acceptance closes the input for a while.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second pair accepted while one is in flight");

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stereo widener with Haas delay.
// A directed table covers silence, full-scale pairs, the anti-correlation
// width guard, width reloads, dry and wet blends, gain extremes, zero and
// maximum delay and ignored register writes. Eight randomised register
// settings with about 1800 random pairs follow. Every output beat is checked
// against fixed values or against a behavioural copy of the widener in the bench.
// ----------------------------------------------------------------------------
module tb;
   import swh_pkg::*;

   localparam int SB          = SAMPLE_BITS_DEF;
   localparam int DEPTH       = DELAY_DEPTH_DEF;
   localparam int PTR_BITS    = $clog2(DEPTH);
   localparam longint SMAX    = (longint'(1) << (SB - 1)) - 1;
   localparam longint SMIN    = -SMAX - 1;
   localparam longint ANTI_LIMIT = (longint'(1) << (2 * (SB - 1))) / 120;
   localparam logic [15:0] MIX_FULL  = 16'hFFFF;
   localparam logic [15:0] WIDTH_TOP = 16'hFFFF;
   localparam logic [15:0] MONO_TOP  = 16'hFFFF;
   localparam logic [15:0] GAIN_TOP  = 16'h7FFF;
   localparam logic [15:0] DELAY_TOP = 16'h0FFF;
   // Indexes beyond the register map; writes there must be dropped.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HI = 3'd7;
   localparam int RANDOM_SETTINGS  = 8;
   localparam int PAIRS_PER_SETTING = 225;
   localparam int IDLE_PERCENT     = 34;
   localparam int SETTLE_CYCLES    = 16;
   localparam int MAX_REPORTS      = 100;
   localparam int unsigned CYCLE_LIMIT = 400000;

   typedef logic signed [SB-1:0] sample_type;
   typedef logic [PTR_BITS-1:0] ptr_type;

   typedef struct {
      sample_type left;
      sample_type right;
   } pair_type;

   typedef struct {
      bit                         is_csr;
      logic [CSR_INDEX_BITS-1:0]  idx;
      logic [CSR_DATA_BITS-1:0]   data;
      sample_type                 left;
      sample_type                 right;
      bit                         block_start;
      bit                         known;
      sample_type                 exp_left;
      sample_type                 exp_right;
   } plan_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0]   csr_wdata = '0;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   sample_type                 req_left_in = '0;
   sample_type                 req_right_in = '0;
   logic                       req_block_start = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   sample_type                 rsp_left_out;
   sample_type                 rsp_right_out;

   stereo_widener_haas_delay_top dut (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_left_in     (req_left_in),
      .req_right_in    (req_right_in),
      .req_block_start (req_block_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_left_out    (rsp_left_out),
      .rsp_right_out   (rsp_right_out)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bench copy of the widener state and registers.
   sample_type   echo_line [DEPTH];
   ptr_type      echo_wr;
   logic [15:0]  cur_width;
   logic [15:0]  reg_width;
   logic [15:0]  reg_mono;
   logic [15:0]  reg_mix;
   logic [14:0]  reg_gain;
   logic [11:0]  reg_delay;

   pair_type     pending_out [$];
   plan_row_type plan [$];
   bit           no_gaps = 1'b0;
   int           fail_count = 0;
   int           beats_checked = 0;
   int           pairs_sent = 0;
   int           reg_writes = 0;
   int           guard_hits = 0;
   int unsigned  cycle_count = 0;

   function automatic longint clip(input longint v);
      if (v > SMAX) return SMAX;
      if (v < SMIN) return SMIN;
      return v;
   endfunction

   // Divide by 2^s, rounding half up.
   function automatic longint round_sh(input longint v, input int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic void apply_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                                     input logic [CSR_DATA_BITS-1:0] data);
      case (idx)
         CSR_WIDTH: reg_width = data;
         CSR_MONO:  reg_mono  = data;
         CSR_MIX:   reg_mix   = data;
         CSR_GAIN:  reg_gain  = data[14:0];
         CSR_DELAY: reg_delay = data[11:0];
         default: ;
      endcase
   endfunction

   function automatic void widen_pair(input sample_type l_in, input sample_type r_in,
                                      input bit block_start,
                                      output sample_type l_out, output sample_type r_out);
      longint l, r, shrink, sum, side, wet_l, wet_r, mix_q, bl, br;
      ptr_type rd_ptr;
      l = l_in;
      r = r_in;
      if (block_start) cur_width = reg_width;
      if (l * r < -ANTI_LIMIT) begin
         shrink = 65536 - (longint'(reg_mono) * 13 + 10) / 20;
         cur_width = 16'((longint'(cur_width) * shrink + 32768) >>> 16);
         guard_hits++;
      end
      sum   = (l + r) * 65536;
      side  = (l - r) * (65536 + longint'(cur_width));
      wet_l = clip(round_sh(sum + side, 17));
      wet_r = clip(round_sh(sum - side, 17));
      echo_line[echo_wr] = sample_type'(wet_r);
      rd_ptr = echo_wr - ptr_type'(reg_delay);
      wet_r = echo_line[rd_ptr];
      mix_q = (reg_mix == MIX_FULL) ? longint'(65536) : longint'(reg_mix);
      bl = round_sh(l * 65536 + mix_q * (wet_l - l), 16);
      br = round_sh(r * 65536 + mix_q * (wet_r - r), 16);
      l_out = sample_type'(clip(round_sh(bl * longint'(reg_gain), 12)));
      r_out = sample_type'(clip(round_sh(br * longint'(reg_gain), 12)));
      echo_wr = echo_wr + 1'b1;
   endfunction

   function automatic void plan_pair(input sample_type l, input sample_type r,
                                     input bit block_start);
      plan_row_type row;
      row = '{default: '0};
      row.left = l;
      row.right = r;
      row.block_start = block_start;
      plan.insert(plan.size(), row);
   endfunction

   function automatic void plan_known(input sample_type l, input sample_type r,
                                      input bit block_start,
                                      input sample_type el, input sample_type er);
      plan_row_type row;
      row = '{default: '0};
      row.left = l;
      row.right = r;
      row.block_start = block_start;
      row.known = 1'b1;
      row.exp_left = el;
      row.exp_right = er;
      plan.insert(plan.size(), row);
   endfunction

   function automatic void plan_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                                    input logic [CSR_DATA_BITS-1:0] data);
      plan_row_type row;
      row = '{default: '0};
      row.is_csr = 1'b1;
      row.idx = idx;
      row.data = data;
      plan.insert(plan.size(), row);
   endfunction

   function automatic logic [15:0] pick_reg(input logic [15:0] top);
      case ($urandom_range(3))
         0: return '0;
         1: return top;
         default: return 16'($urandom_range(top));
      endcase
   endfunction

   // Presents one pair and records the expected output once it is taken.
   task automatic push_pair(input sample_type l, input sample_type r, input bit block_start,
                            input bit known, input sample_type el, input sample_type er);
      pair_type p;
      @(negedge clock);
      while (!no_gaps && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_left_in <= l;
      req_right_in <= r;
      req_block_start <= block_start;
      do @(posedge clock); while (!req_ready);
      widen_pair(l, r, block_start, p.left, p.right);
      if (known) begin
         p.left = el;
         p.right = er;
      end
      pending_out.insert(pending_out.size(), p);
      pairs_sent++;
   endtask

   // Registers may only change with no pair in flight.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_out.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      settle();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      apply_reg(idx, data);
      reg_writes++;
   endtask

   always @(negedge clock) begin
      rsp_ready <= no_gaps || ($urandom_range(99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin
      pair_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         beats_checked++;
         if (pending_out.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("%0t: output beat with nothing expected (left %0d, right %0d)",
                        $time, rsp_left_out, rsp_right_out);
         end else begin
            want = pending_out.pop_front();
            if (rsp_left_out !== want.left) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t: left_out expected %0d, got %0d",
                           $time, want.left, rsp_left_out);
            end
            if (rsp_right_out !== want.right) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t: right_out expected %0d, got %0d",
                           $time, want.right, rsp_right_out);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run stopped after %0d cycles with %0d beats outstanding",
                  $time, cycle_count, pending_out.size());
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      sample_type a, b;
      longint t;
      bit bs;
      logic [15:0] v_width, v_mono, v_mix, v_gain, v_delay;

      for (int i = 0; i < DEPTH; i++) echo_line[i] = '0;
      echo_wr   = '0;
      cur_width = WIDTH_RESET;
      reg_width = WIDTH_RESET;
      reg_mono  = MONO_RESET;
      reg_mix   = MIX_RESET;
      reg_gain  = GAIN_RESET;
      reg_delay = DELAY_RESET;

      // Directed table. Fully wet, unity gain and a 576-sample delay to begin.
      plan_known('0, '0, 1'b1, '0, '0);
      plan_pair(sample_type'(SMAX), sample_type'(SMAX), 1'b0);
      plan_pair(sample_type'(SMIN), sample_type'(SMIN), 1'b0);
      // Full-scale opposite signs: the guard engages and the side term saturates.
      plan_pair(sample_type'(SMAX), sample_type'(SMIN), 1'b0);
      plan_pair(sample_type'(SMIN), sample_type'(SMAX), 1'b0);
      plan_pair(sample_type'(1), sample_type'(-1), 1'b0);
      plan_pair(sample_type'(3000000), sample_type'(-3000000), 1'b0);
      plan_pair(sample_type'(3000000), sample_type'(-3000000), 1'b0);
      plan_pair(sample_type'(2000000), sample_type'(-2500000), 1'b1);
      // A new width only counts from the next block start.
      plan_csr(CSR_WIDTH, WIDTH_TOP);
      plan_pair(sample_type'(-4000000), sample_type'(1000000), 1'b0);
      plan_pair(sample_type'(-4000000), sample_type'(1000000), 1'b1);
      // Fully dry at unity gain passes the input straight through.
      plan_csr(CSR_MIX, '0);
      plan_csr(CSR_DELAY, '0);
      plan_known(sample_type'(SMAX), sample_type'(SMIN), 1'b0,
                 sample_type'(SMAX), sample_type'(SMIN));
      plan_known(sample_type'(-1), sample_type'(1), 1'b0, sample_type'(-1), sample_type'(1));
      plan_csr(CSR_GAIN, '0);
      plan_known(sample_type'(SMAX), sample_type'(SMAX), 1'b0, '0, '0);
      plan_csr(CSR_SPARE_LO, 16'h1234);
      plan_pair(sample_type'(123456), sample_type'(-654321), 1'b0);
      plan_csr(CSR_GAIN, GAIN_TOP);
      plan_csr(CSR_MIX, MIX_FULL);
      plan_csr(CSR_MONO, '0);
      plan_pair(sample_type'(SMIN), sample_type'(SMIN), 1'b1);
      plan_csr(CSR_DELAY, DELAY_TOP);
      plan_csr(CSR_MONO, MONO_TOP);
      plan_pair(sample_type'(SMAX), sample_type'(SMIN), 1'b0);
      plan_pair(sample_type'(5000000), sample_type'(-5000000), 1'b0);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[k]) begin
         if (plan[k].is_csr)
            csr_write(plan[k].idx, plan[k].data);
         else
            push_pair(plan[k].left, plan[k].right, plan[k].block_start,
                      plan[k].known, plan[k].exp_left, plan[k].exp_right);
      end

      for (int ph = 0; ph < RANDOM_SETTINGS; ph++) begin
         case (ph)
            0: begin
               v_width = '0; v_mono = '0; v_mix = '0;
               v_gain = GAIN_RESET; v_delay = '0;
            end
            1: begin
               v_width = WIDTH_TOP; v_mono = MONO_TOP; v_mix = MIX_FULL;
               v_gain = GAIN_TOP; v_delay = DELAY_TOP;
            end
            default: begin
               v_width = pick_reg(WIDTH_TOP);
               v_mono  = pick_reg(MONO_TOP);
               v_mix   = pick_reg(MIX_FULL);
               v_gain  = (ph == 2) ? 16'h0 : pick_reg(GAIN_TOP);
               v_delay = pick_reg(DELAY_TOP);
               // Bits above a narrow register must be dropped by the block.
               if ($urandom_range(3) == 0) v_gain  = v_gain  | (16'($urandom) & ~GAIN_TOP);
               if ($urandom_range(3) == 0) v_delay = v_delay | (16'($urandom) & ~DELAY_TOP);
            end
         endcase
         csr_write(CSR_WIDTH, v_width);
         csr_write(CSR_MONO, v_mono);
         csr_write(CSR_MIX, v_mix);
         csr_write(CSR_GAIN, v_gain);
         csr_write(CSR_DELAY, v_delay);
         csr_write(3'($urandom_range(CSR_SPARE_HI, CSR_SPARE_LO)), 16'($urandom));
         no_gaps = (ph == 4);

         for (int i = 0; i < PAIRS_PER_SETTING; i++) begin
            a  = sample_type'($urandom);
            b  = sample_type'($urandom);
            bs = (i == 0) || ($urandom_range(39) == 0);
            case ($urandom_range(9))
               3, 4: begin
                  t = -longint'(a) + longint'($urandom_range(2000)) - 1000;
                  b = sample_type'(clip(t));
               end
               5: begin
                  t = longint'(a) + longint'($urandom_range(2000)) - 1000;
                  b = sample_type'(clip(t));
               end
               6: begin
                  a = sample_type'(longint'($urandom_range(2048)) - 1024);
                  b = sample_type'(longint'($urandom_range(2048)) - 1024);
               end
               7: begin
                  case ($urandom_range(4))
                     0: a = sample_type'(SMAX);
                     1: a = sample_type'(SMIN);
                     2: a = '0;
                     3: a = sample_type'(-1);
                     default: a = sample_type'(1);
                  endcase
                  b = ($urandom_range(1) == 0) ? sample_type'(SMIN) : sample_type'(SMAX);
               end
               default: ;
            endcase
            push_pair(a, b, bs, 1'b0, '0, '0);
         end
      end
      no_gaps = 1'b0;

      settle();
      repeat (32) @(posedge clock);
      $display("Run covered %0d stereo pairs and %0d register writes over %0d settings.",
               pairs_sent, reg_writes, RANDOM_SETTINGS + 1);
      $display("The width guard engaged on %0d pairs; %0d output beats were compared.",
               guard_hits, beats_checked);
      if (fail_count == 0 && pending_out.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
